FILE: hdl/tkft_pkg.sv
package tkft_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int INC_W   = 16;

    // request kinds
    localparam logic KIND_UPDATE   = 1'b0;
    localparam logic KIND_ESTIMATE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   key;
        logic [INC_W-1:0]   increment;
    } req_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               was_tracked;
        logic               replaced;
    } rsp_item_t;

    // one table row: key and its count share a RAM word
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/top_k_frequency_tracker_top.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_item_t: kind, key, increment
// rsp     | out       | rsp_valid/rsp_stall | rsp_item_t: count, was_tracked, replaced
//
// Flow: a request is scanned by reading one table row per cycle through the
// single RAM port, then the commit step writes an update back. The next
// request can transfer in the cycle its result shows.
// Reset: rst_n clears the fill level, sequencer and result valid; the table
// RAM is not cleared, rows above the fill level are never read.
// Stalls: rsp_stall holds the result register; a finished request waits in
// commit until that register is free. req_stall is high while a request is busy.
module top_k_frequency_tracker_top
    import tkft_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;       // valid rows 0 .. fill-1
    logic [FILL_W-1:0]    rd_idx_reg, rd_idx_next;   // next row to read
    logic                 pend_reg, pend_next;       // read data arrives this cycle
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    req_item_t            op_reg, op_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;
    logic [COUNT_W-1:0]   min_cnt_reg, min_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_reg, rsp_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    logic                 issue;
    logic                 table_full;
    logic                 out_free;
    logic [COUNT_W-1:0]   add_base;
    logic [COUNT_W:0]     add_sum;
    logic [COUNT_W-1:0]   sat_sum;

    tkft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_entry   = entry_t'(ram_rdata);
    assign issue      = (rd_idx_reg < fill_reg);
    assign table_full = (fill_reg == FILL_W'(CAPACITY));
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // the count adder: saturating count update at commit
    assign add_base = found_reg ? hit_cnt_reg : min_cnt_reg;
    assign add_sum  = {1'b0, add_base} + {{(COUNT_W + 1 - INC_W){1'b0}}, op_reg.increment};
    assign sat_sum  = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        op_next        = op_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        min_idx_next   = min_idx_reg;
        min_cnt_next   = min_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_addr       = rd_idx_reg[IDX_W-1:0];
        ram_wdata      = '{key: op_reg.key, count: sat_sum};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req;
                    found_next  = 1'b0;
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare the row that comes back
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + FILL_W'(1);
                end
                if (pend_reg)
                begin
                    if (!found_reg && (rd_entry.key == op_reg.key))
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = pend_idx_reg;
                        hit_cnt_next = rd_entry.count;
                    end
                    // strict less-than keeps the lowest index on ties
                    if ((pend_idx_reg == '0) || (rd_entry.count < min_cnt_reg))
                    begin
                        min_idx_next = pend_idx_reg;
                        min_cnt_next = rd_entry.count;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.was_tracked = found_reg;
                    rsp_next.replaced    = 1'b0;
                    state_next           = ST_IDLE;
                    if (op_reg.kind == KIND_ESTIMATE)
                    begin
                        rsp_next.count = found_reg ? hit_cnt_reg : '0;
                    end
                    else if (found_reg)
                    begin
                        ram_we         = 1'b1;
                        ram_addr       = hit_idx_reg;
                        rsp_next.count = sat_sum;
                    end
                    else if (!table_full)
                    begin
                        // append a new row
                        ram_we          = 1'b1;
                        ram_addr        = fill_reg[IDX_W-1:0];
                        ram_wdata.count = {{(COUNT_W - INC_W){1'b0}}, op_reg.increment};
                        rsp_next.count  = {{(COUNT_W - INC_W){1'b0}}, op_reg.increment};
                        fill_next       = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        // evict the minimum, inherit its count
                        ram_we            = 1'b1;
                        ram_addr          = min_idx_reg;
                        rsp_next.count    = sat_sum;
                        rsp_next.replaced = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            op_reg        <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            hit_cnt_reg   <= '0;
            min_idx_reg   <= '0;
            min_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            op_reg        <= op_next;
            found_reg     <= found_next;
            hit_idx_reg   <= hit_idx_next;
            hit_cnt_reg   <= hit_cnt_next;
            min_idx_reg   <= min_idx_next;
            min_cnt_reg   <= min_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/tkft_ram.sv
module tkft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/tkft_checker.sv
module tkft_checker
    import tkft_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // a held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // a request transfer makes the block busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not stalled after transfer");

    // a new result only appears out of a busy request
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in progress");

    // eviction only happens for keys that were not tracked
    a_replace_untracked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.replaced |-> !rsp.was_tracked)
        else $error("replaced set on a tracked key");

endmodule

bind top_k_frequency_tracker_top tkft_checker u_tkft_checker (.*);

FILE: test/tb_top_k_frequency_tracker_top.sv
module tb_top_k_frequency_tracker_top
    import tkft_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = 64;
    // A full-table scan reads every valid row. Margin is added for the result stall.
    localparam int DRAIN_CYCLES   = CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 96;    // more keys than rows, so rows keep churning
    localparam int RANDOM_ITEMS   = 436;
    localparam int MAX_REPORTS    = 50;

    // ------------------------------------------------------------------
    // Scoreboard: a shadow copy of the heavy-hitter table. It predicts
    // each result when its request transfers, and it checks results in order.
    // ------------------------------------------------------------------
    class heavy_hitter_scoreboard;
        bit [KEY_W-1:0]   row_key   [CAPACITY];
        bit [COUNT_W-1:0] row_count [CAPACITY];
        int unsigned      fill         = 0;
        rsp_item_t        expected_rsp [$];
        int unsigned      errors       = 0;
        int unsigned      replacements = 0;

        function bit [COUNT_W-1:0] sat_sum(bit [COUNT_W-1:0] a, bit [INC_W-1:0] b);
            bit [COUNT_W:0] s;
            s = {1'b0, a} + {{(COUNT_W + 1 - INC_W){1'b0}}, b};
            return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
        endfunction

        // Count a failure. Returns 1 while the failure count is at most the cap.
        function bit flag();
            errors++;
            return errors <= MAX_REPORTS;
        endfunction

        function void note_request(req_item_t r);
            bit          found;
            int unsigned hit;
            int unsigned low;
            rsp_item_t   exp;
            found = 1'b0;
            hit   = 0;
            low   = 0;
            exp   = '0;
            // Find the first key match and the lowest count. On a tie the lower index wins.
            for (int unsigned i = 0; i < fill; i++)
            begin
                if (!found && row_key[i] == r.key)
                begin
                    found = 1'b1;
                    hit   = i;
                end
                if (row_count[i] < row_count[low])
                    low = i;
            end
            exp.was_tracked = found;
            if (r.kind == KIND_ESTIMATE)
                exp.count = found ? row_count[hit] : '0;
            else if (found)
            begin
                row_count[hit] = sat_sum(row_count[hit], r.increment);
                exp.count      = row_count[hit];
            end
            else if (fill < CAPACITY)
            begin
                row_key[fill]   = r.key;
                row_count[fill] = COUNT_W'(r.increment);
                exp.count       = COUNT_W'(r.increment);
                fill++;
            end
            else
            begin
                // the new key takes the lowest row and keeps the count it inherits
                row_key[low]   = r.key;
                row_count[low] = sat_sum(row_count[low], r.increment);
                exp.count      = row_count[low];
                exp.replaced   = 1'b1;
            end
            expected_rsp = {expected_rsp, exp};
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t exp;
            if (expected_rsp.size() == 0)
            begin
                if (flag())
                    $display("%0t: result with nothing expected: count=%h tracked=%b replaced=%b",
                             $time, got.count, got.was_tracked, got.replaced);
                return;
            end
            exp = expected_rsp.pop_front();
            if (exp.replaced)
                replacements++;
            if (got.count !== exp.count || got.was_tracked !== exp.was_tracked ||
                got.replaced !== exp.replaced)
            begin
                if (flag())
                    $display("%0t: mismatch: expected count=%h tracked=%b replaced=%b, %s",
                             $time, exp.count, exp.was_tracked, exp.replaced,
                             $sformatf("got count=%h tracked=%b replaced=%b",
                                       got.count, got.was_tracked, got.replaced));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup. Every input has a known value at time zero.
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    bit                     no_idle = 1'b0;  // while set, neither side idles
    int unsigned            updates_sent   = 0;
    int unsigned            estimates_sent = 0;
    bit [KEY_W-1:0]         key_pool [POOL_SIZE];
    heavy_hitter_scoreboard board = new();

    top_k_frequency_tracker_top #(.CAPACITY(CAPACITY)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Monitors: values are sampled at the rising edge, before the DUT updates its registers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
        end
    end

    // Result side: the stall is held at random about a third of the time.
    always @(negedge clk)
        rsp_stall <= !no_idle && ($urandom_range(99) < 33);

    // Watchdog: the run is stuck if no transfer happens on either channel for too long.
    initial
    begin
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, WATCHDOG_LIMIT, board.expected_rsp.size());
        $display("FAIL top_k_frequency_tracker_top");
        $finish;
    end

    function automatic req_item_t mk(logic kind, logic [KEY_W-1:0] key,
                                     logic [INC_W-1:0] increment);
        req_item_t r;
        r.kind      = kind;
        r.key       = key;
        r.increment = increment;
        return r;
    endfunction

    // Mostly keys from a pool slightly larger than the table, so hits, misses
    // and evictions all happen. Zero and small increments give count ties.
    function automatic req_item_t random_request();
        req_item_t   r;
        int unsigned roll;
        r.kind = ($urandom_range(99) < 25) ? KIND_ESTIMATE : KIND_UPDATE;
        r.key  = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                           : $urandom();
        roll   = $urandom_range(99);
        if (roll < 20)
            r.increment = '0;
        else if (roll < 30)
            r.increment = '1;
        else if (roll < 80)
            r.increment = INC_W'($urandom_range(8, 1));
        else
            r.increment = INC_W'($urandom());
        return r;
    endfunction

    // Called at a falling edge. Returns at the falling edge after the transfer.
    task automatic send(input req_item_t item);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        if (item.kind == KIND_ESTIMATE)
            estimates_sent++;
        else
            updates_sent++;
    endtask

    // Hold off new requests until every result that is due has come.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (board.expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part ---
        send(mk(KIND_ESTIMATE, '0, '0));            // estimate on an empty table
        send(mk(KIND_UPDATE, '1, '1));              // first row, largest increment
        send(mk(KIND_UPDATE, '1, 16'h0001));
        send(mk(KIND_ESTIMATE, '1, '1));

        send(mk(KIND_UPDATE, '0, '0));              // new key enters with count 0
        send(mk(KIND_UPDATE, '0, '0));              // hit, zero increment
        send(mk(KIND_UPDATE, '0, '1));
        send(mk(KIND_ESTIMATE, '0, 16'h1234));      // increment is ignored on an estimate
        send(mk(KIND_ESTIMATE, 32'h8000_0000, '0)); // untracked key
        send(mk(KIND_UPDATE, 32'hAAAA_AAAA, 16'h5555));
        send(mk(KIND_UPDATE, 32'h5555_5555, 16'hAAAA));
        send(mk(KIND_UPDATE, 32'h8000_0000, 16'h8000));
        send(mk(KIND_UPDATE, 32'h0000_0001, 16'h0001));
        send(mk(KIND_ESTIMATE, 32'hAAAA_AAAA, '0));
        send(mk(KIND_ESTIMATE, 32'h5555_5555, '1));

        // --- random part: fills the table, then churns it with evictions ---
        // The first quarter is the long stretch with no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n < RANDOM_ITEMS / 4);
            if (n == RANDOM_ITEMS / 2)
                drain();                            // sender pauses until the pipe is empty
            send(random_request());
        end
        no_idle = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (board.expected_rsp.size() != 0)
        begin
            board.errors++;
            $display("%0t: %0d expected results never arrived", $time, board.expected_rsp.size());
        end
        $display("Sent %0d updates and %0d estimates, with %0d evictions of the lowest row.",
                 updates_sent, estimates_sent, board.replacements);
        $display("Failures: %0d.", board.errors);
        if (board.errors == 0)
            $display("PASS top_k_frequency_tracker_top");
        else
            $display("FAIL top_k_frequency_tracker_top");
        $finish;
    end

endmodule
